// ===== rtl/first_unique_symbol_tracker_top_macros.svh =====
// Assertion macros for the first unique symbol tracker.
// Used by the tracker top level; no other dependencies.
`ifndef FIRST_UNIQUE_SYMBOL_TRACKER_TOP_MACROS_SVH
`define FIRST_UNIQUE_SYMBOL_TRACKER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FUST_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define FUST_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fust_pkg.sv =====
// Shared types and constants of the first unique symbol tracker.
// No dependencies; imported by the output queue and the top level.
`timescale 1ns / 1ps

package fust_pkg;

    localparam int SYM_W             = 8;
    localparam int ALPHABET_SIZE_DEF = 256;
    localparam logic [SYM_W-1:0] NONE_MARK = 8'd35;

    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] ST_UNSEEN   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ONCE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REPEATED = 2'd2;

    localparam int OQ_DEPTH = 3;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    typedef struct packed {
        logic             found;
        logic [SYM_W-1:0] first_unique;
    } result_t;

endpackage

// ===== rtl/fust_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Read-first on a same-address write; no dependencies.
`timescale 1ns / 1ps

module fust_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/fust_out_queue.sv =====
// Three-entry result queue between the list update stage and the m_ port.
// Depends on fust_pkg for the result type and queue sizing.
`timescale 1ns / 1ps

module fust_out_queue (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  fust_pkg::result_t         push_data,
    input  logic                      pop,
    output logic                      out_valid,
    output fust_pkg::result_t         out_data,
    output logic [fust_pkg::OQ_CNT_W-1:0] count
);
    import fust_pkg::*;

    result_t               entry_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OQ_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OQ_CNT_W-1:0]   count_reg, count_next;
    logic                  do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

// ===== rtl/first_unique_symbol_tracker_top.sv =====
// Throughput: one transaction per cycle while s_ready is high; each transaction is registered
// at accept; its result then enters the queue that drives the m_ ports. Status and link RAMs
// are read at accept, written back the next cycle, with write-to-read forwarding on each RAM.
// Reset (aresetn, synchronous, active low) empties the list, valid bits and result queue;
// link RAM contents stay undefined and need no clearing pass; restart clears the list first.
`timescale 1ns / 1ps

module first_unique_symbol_tracker_top #(
    parameter int ALPHABET_SIZE = fust_pkg::ALPHABET_SIZE_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [fust_pkg::SYM_W-1:0] s_symbol,
    input  logic                       s_restart,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_found,
    output logic [fust_pkg::SYM_W-1:0] m_first_unique
);
    import fust_pkg::*;
`include "first_unique_symbol_tracker_top_macros.svh"

    localparam int IDX_W  = $clog2(ALPHABET_SIZE);
    localparam int LINK_W = IDX_W + 1;
    localparam int CMP_W  = (LINK_W > SYM_W) ? LINK_W : SYM_W;
    localparam logic [LINK_W-1:0] NONE_LINK = {1'b1, {IDX_W{1'b0}}};

    logic                 accept;
    logic [CMP_W-1:0]     sym_ext;
    logic [IDX_W-1:0]     rd_idx;

    logic                 stage_valid_reg;
    logic [IDX_W-1:0]     sym_reg;
    logic                 range_reg;
    logic                 restart_reg;

    logic [LINK_W-1:0]    head_reg, head_next;
    logic [LINK_W-1:0]    tail_reg, tail_next;
    logic [ALPHABET_SIZE-1:0] valid_reg, valid_next;

    logic                 st_we, nx_we, pv_we;
    logic [IDX_W-1:0]     st_waddr, nx_waddr, pv_waddr;
    logic [STATUS_W-1:0]  st_wdata, st_rdata;
    logic [LINK_W-1:0]    nx_wdata, pv_wdata, nx_rdata, pv_rdata;

    logic                 st_fwd_reg, nx_fwd_reg, pv_fwd_reg;
    logic [STATUS_W-1:0]  st_fwd_data_reg;
    logic [LINK_W-1:0]    nx_fwd_data_reg, pv_fwd_data_reg;

    logic [LINK_W-1:0]    head_cur, tail_cur, sym_link;
    logic [STATUS_W-1:0]  status_cur;
    logic [LINK_W-1:0]    next_cur, prev_cur, after_link, before_link;
    logic                 entry_valid, do_append, do_unlink;
    logic [CMP_W-1:0]     head_ext;

    result_t              result;
    result_t              q_data;
    logic [OQ_CNT_W-1:0]  q_count;

    // Accept side
    assign s_ready = stage_valid_reg ? (q_count < OQ_CNT_W'(OQ_DEPTH - 1))
                                     : (q_count < OQ_CNT_W'(OQ_DEPTH));
    assign accept  = s_valid && s_ready;
    assign sym_ext = CMP_W'(s_symbol);
    assign rd_idx  = sym_ext[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sym_reg     <= rd_idx;
            range_reg   <= (sym_ext < CMP_W'(ALPHABET_SIZE));
            restart_reg <= s_restart;
            st_fwd_reg  <= st_we && (st_waddr == rd_idx);
            nx_fwd_reg  <= nx_we && (nx_waddr == rd_idx);
            pv_fwd_reg  <= pv_we && (pv_waddr == rd_idx);
            st_fwd_data_reg <= st_wdata;
            nx_fwd_data_reg <= nx_wdata;
            pv_fwd_data_reg <= pv_wdata;
        end
    end

    // State memories
    fust_ram #(.WIDTH(STATUS_W), .DEPTH(ALPHABET_SIZE)) u_status_ram (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (accept),
        .raddr (rd_idx),
        .rdata (st_rdata)
    );

    fust_ram #(.WIDTH(LINK_W), .DEPTH(ALPHABET_SIZE)) u_next_ram (
        .aclk  (aclk),
        .we    (nx_we),
        .waddr (nx_waddr),
        .wdata (nx_wdata),
        .re    (accept),
        .raddr (rd_idx),
        .rdata (nx_rdata)
    );

    fust_ram #(.WIDTH(LINK_W), .DEPTH(ALPHABET_SIZE)) u_prev_ram (
        .aclk  (aclk),
        .we    (pv_we),
        .waddr (pv_waddr),
        .wdata (pv_wdata),
        .re    (accept),
        .raddr (rd_idx),
        .rdata (pv_rdata)
    );

    // Update stage
    assign head_cur    = restart_reg ? NONE_LINK : head_reg;
    assign tail_cur    = restart_reg ? NONE_LINK : tail_reg;
    assign sym_link    = {1'b0, sym_reg};
    assign entry_valid = !restart_reg && range_reg && valid_reg[sym_reg];
    assign status_cur  = !entry_valid ? ST_UNSEEN : (st_fwd_reg ? st_fwd_data_reg : st_rdata);
    assign next_cur    = nx_fwd_reg ? nx_fwd_data_reg : nx_rdata;
    assign prev_cur    = pv_fwd_reg ? pv_fwd_data_reg : pv_rdata;
    assign after_link  = (tail_cur == sym_link) ? NONE_LINK : next_cur;
    assign before_link = prev_cur;

    assign do_append = stage_valid_reg && range_reg && (status_cur == ST_UNSEEN);
    assign do_unlink = stage_valid_reg && range_reg && (status_cur == ST_ONCE);

    always_comb begin
        st_we    = do_append || do_unlink;
        st_waddr = sym_reg;
        st_wdata = do_append ? ST_ONCE : ST_REPEATED;
        nx_we    = 1'b0;
        nx_waddr = tail_cur[IDX_W-1:0];
        nx_wdata = sym_link;
        pv_we    = 1'b0;
        pv_waddr = sym_reg;
        pv_wdata = tail_cur;
        head_next = head_cur;
        tail_next = tail_cur;
        valid_next = restart_reg ? '0 : valid_reg;
        if (do_append) begin
            pv_we = 1'b1;
            nx_we = !tail_cur[IDX_W];
            if (tail_cur[IDX_W]) begin
                head_next = sym_link;
            end
            tail_next = sym_link;
            valid_next[sym_reg] = 1'b1;
        end else if (do_unlink) begin
            nx_we    = !before_link[IDX_W];
            nx_waddr = before_link[IDX_W-1:0];
            nx_wdata = after_link;
            pv_we    = !after_link[IDX_W];
            pv_waddr = after_link[IDX_W-1:0];
            pv_wdata = before_link;
            if (before_link[IDX_W]) begin
                head_next = after_link;
            end
            if (after_link[IDX_W]) begin
                tail_next = before_link;
            end
            valid_next[sym_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= NONE_LINK;
            tail_reg  <= NONE_LINK;
            valid_reg <= '0;
        end else if (stage_valid_reg) begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            valid_reg <= valid_next;
        end
    end

    assign head_ext            = CMP_W'(head_next[IDX_W-1:0]);
    assign result.found        = !head_next[IDX_W];
    assign result.first_unique = head_next[IDX_W] ? NONE_MARK : head_ext[SYM_W-1:0];

    // Result queue
    fust_out_queue u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (stage_valid_reg),
        .push_data (result),
        .pop       (m_ready),
        .out_valid (m_valid),
        .out_data  (q_data),
        .count     (q_count)
    );

    assign m_found        = q_data.found;
    assign m_first_unique = q_data.first_unique;

    `FUST_ASSERT_NOW(a_ends_agree, aclk, aresetn, 1'b1, head_reg[IDX_W] == tail_reg[IDX_W], "head and tail disagree on empty list")
    `FUST_ASSERT_NOW(a_queue_room, aclk, aresetn, stage_valid_reg, q_count < OQ_CNT_W'(OQ_DEPTH), "result pushed into full queue")
    `FUST_ASSERT_NEXT(a_append_tail, aclk, aresetn, do_append, tail_reg == $past(sym_link), "appended symbol is not the tail")
    `FUST_ASSERT_NEXT(a_restart_valid, aclk, aresetn, stage_valid_reg && restart_reg, $countones(valid_reg) <= 1, "restart left stale status entries")

endmodule
